// ----- design/kpl_pkg.sv -----
// Shared widths, constants and operation codes for the keyed pool.
package kpl_pkg;

  localparam int KEY_W        = 64;
  localparam int STAMP_W      = 32;
  localparam int AGE_W        = 10;
  localparam int SLOT_W       = 3;
  localparam int OUT_TDATA_W  = 8;

  localparam logic [AGE_W-1:0]   AGE_LIMIT_RESET = 10'd10;
  localparam logic [STAMP_W-1:0] STAMP_NONE      = 32'hFFFF_FFFF;

  // operation codes carried in tuser
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // output tdata bit positions
  localparam int OUT_HIT_BIT  = 0;
  localparam int OUT_SLOT_LO  = 1;
  localparam int OUT_REPL_BIT = 4;

endpackage

// ----- design/keyed_pool_lru_with_age_eviction.sv -----
// Keyed pool with LRU replacement and age eviction: sequencer, entry store and result register.
//
// A lookup beat carries a 64-bit key (in_tdata) and the operation in in_tuser (0 lookup,
// 1 flush). One entry is examined per clock by a single shared key comparator and stamp
// comparator, so a lookup occupies the block through a search over all entries (first live
// match and oldest stamp together), an update step, an age check over all entries, and a
// step that waits to load the result register. A flush clears the pool and goes straight
// to the result step. in_tready is high only while the sequencer is idle;
// a finished result waits in the output register, and the next item may be accepted while it
// does. The age limit is written through cfg_valid/cfg_data, which is always ready and must
// only be used while the block is idle.
module keyed_pool_lru_with_age_eviction #(
  parameter int POOL_ENTRIES = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration: age limit
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kpl_pkg::AGE_W-1:0]         cfg_data,
  // request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [kpl_pkg::KEY_W-1:0]         in_tdata,   // [63:0] key
  input  logic                              in_tuser,   // [0] operation
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kpl_pkg::OUT_TDATA_W-1:0]   out_tdata   // [0] hit, [3:1] slot,
                                                        // [4] replaced_live, [7:5] zero
);

  localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_ENTRIES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_AGE    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // entry store
  logic [kpl_pkg::KEY_W-1:0]   keys   [POOL_ENTRIES];
  logic [kpl_pkg::STAMP_W-1:0] stamps [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0]     live;

  logic [kpl_pkg::STAMP_W-1:0] tick;
  logic [kpl_pkg::AGE_W-1:0]   age_limit;

  logic [2:0]                  state;
  logic [IDX_W-1:0]            idx;
  logic [kpl_pkg::KEY_W-1:0]   key_reg;
  logic                        found;
  logic [IDX_W-1:0]            slot;
  logic [IDX_W-1:0]            oldest;
  logic [kpl_pkg::STAMP_W-1:0] min_stamp;
  logic                        was_live;
  logic                        load_out;

  // shared compare unit, driven by the scan index
  logic [kpl_pkg::KEY_W-1:0]   rd_key;
  logic [kpl_pkg::STAMP_W-1:0] rd_stamp;
  logic                        rd_live;
  logic                        key_match;
  logic                        stamp_less;
  logic [kpl_pkg::STAMP_W:0]   age_sum;
  logic                        aged_out;
  logic [IDX_W-1:0]            target;
  logic [IDX_W+kpl_pkg::SLOT_W-1:0] slot_ext;

  always_comb begin
    rd_key     = keys[idx];
    rd_stamp   = stamps[idx];
    rd_live    = live[idx];
    key_match  = rd_live && (rd_key == key_reg);
    stamp_less = rd_stamp < min_stamp;
    age_sum    = {1'b0, rd_stamp} + {{(kpl_pkg::STAMP_W + 1 - kpl_pkg::AGE_W){1'b0}}, age_limit};
    aged_out   = age_sum < {1'b0, tick};
    target     = found ? slot : oldest;
    slot_ext   = {{kpl_pkg::SLOT_W{1'b0}}, slot};
  end

  assign cfg_ready = 1'b1;
  assign in_tready = (state == ST_IDLE);

  // result register takes a finished beat once it is free
  assign load_out = (state == ST_DONE) && (!out_tvalid || out_tready);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= kpl_pkg::AGE_LIMIT_RESET;
    end else if (cfg_valid) begin
      age_limit <= cfg_data;
    end
  end

  // sequencer and entry updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      live       <= '0;
      tick       <= '0;
      found      <= 1'b0;
      slot       <= '0;
      oldest     <= '0;
      was_live   <= 1'b0;
      min_stamp  <= kpl_pkg::STAMP_NONE;
      out_tvalid <= 1'b0;
      out_tdata  <= '0;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        stamps[i] <= '0;
      end
    end else begin
      // result register: load a finished beat, else drop an accepted one
      if (load_out) begin
        out_tvalid <= 1'b1;
        out_tdata  <= {3'b000, was_live, slot_ext[kpl_pkg::SLOT_W-1:0], found};
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_tvalid) begin
            key_reg   <= in_tdata;
            found     <= 1'b0;
            slot      <= '0;
            oldest    <= '0;
            was_live  <= 1'b0;
            min_stamp <= kpl_pkg::STAMP_NONE;
            idx       <= '0;
            if (in_tuser == kpl_pkg::OP_FLUSH) begin
              live <= '0;
              tick <= '0;
              for (int i = 0; i < POOL_ENTRIES; i++) begin
                stamps[i] <= '0;
              end
              state <= ST_DONE;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          // first live match, and oldest stamp on strict less-than
          if (key_match && !found) begin
            found <= 1'b1;
            slot  <= idx;
          end
          if (stamp_less) begin
            min_stamp <= rd_stamp;
            oldest    <= idx;
          end
          if (idx == IDX_LAST) begin
            idx   <= '0;
            state <= ST_UPDATE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_UPDATE: begin
          stamps[target] <= tick;
          if (!found) begin
            keys[target] <= key_reg;
            was_live     <= live[target];
            live[target] <= 1'b1;
            slot         <= oldest;
          end
          state <= ST_AGE;
        end
        ST_AGE: begin
          if (aged_out) begin
            live[idx] <= 1'b0;
          end
          if (idx == IDX_LAST) begin
            idx   <= '0;
            tick  <= tick + 1'b1;
            state <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DONE: begin
          // wait until the result register has taken the beat
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/kpl_checker.sv -----
// Port-level checker for the keyed pool, bound to the top level.
module kpl_checker #(
  parameter int POOL_ENTRIES = 5
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [kpl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // the sequencer is busy the cycle after a request beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // a hit never reports a replacement
  a_hit_no_replace: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && out_tdata[kpl_pkg::OUT_HIT_BIT] |-> !out_tdata[kpl_pkg::OUT_REPL_BIT])
    else $error("hit with replaced_live set");

  // reported slot lies inside the pool
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> (POOL_ENTRIES > 8) ||
      (int'(out_tdata[kpl_pkg::OUT_SLOT_LO +: kpl_pkg::SLOT_W]) < POOL_ENTRIES))
    else $error("slot beyond pool");

endmodule

bind keyed_pool_lru_with_age_eviction kpl_checker #(
  .POOL_ENTRIES(POOL_ENTRIES)
) u_kpl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
